@@ hw/rtl/bdmm_pkg.sv @@
// Shared constants and types for the binary descriptor mutual matcher.
package bdmm_pkg;

  localparam int DESC_W      = 352;
  localparam int QUERY_DEPTH = 64;
  localparam int REF_DEPTH   = 1024;
  localparam int QIDX_W      = 6;
  localparam int RIDX_W      = 10;
  localparam int QCNT_W      = 7;
  localparam int RCNT_W      = 11;
  localparam int DIST_W      = 9;
  localparam int PC_W        = 7;

  typedef struct packed {
    logic              is_ref;
    logic              start;
    logic [DESC_W-1:0] desc;
  } bdmm_cmd_t;

  typedef struct packed {
    logic [RIDX_W-1:0] idx;
    logic [DIST_W-1:0] hdist;
  } bdmm_qbest_t;

  typedef struct packed {
    logic [QIDX_W-1:0] idx;
    logic [DIST_W-1:0] hdist;
  } bdmm_rbest_t;

endpackage

@@ hw/rtl/bdmm_front.sv @@
// Input side: accepts words, classifies them and queues them for the engine.
module bdmm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [63:0]               in_desc_w0,
  input  logic [63:0]               in_desc_w1,
  input  logic [63:0]               in_desc_w2,
  input  logic [63:0]               in_desc_w3,
  input  logic [63:0]               in_desc_w4,
  input  logic [31:0]               in_desc_w5,
  input  logic                      in_set_last,
  output logic                      cmd_valid,
  output bdmm_pkg::bdmm_cmd_t       cmd,
  input  logic                      cmd_pop
);
  import bdmm_pkg::*;

  bdmm_cmd_t  q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  bdmm_cmd_t  in_cmd;

  always_comb begin
    in_cmd.is_ref = in_kind;
    in_cmd.start  = in_kind & in_set_last;
    in_cmd.desc   = {in_desc_w5, in_desc_w4, in_desc_w3, in_desc_w2, in_desc_w1, in_desc_w0};
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/bdmm_back.sv @@
// Engine: stores descriptors, runs the nearest-neighbor search and emits results.
module bdmm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  bdmm_pkg::bdmm_cmd_t           cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    out_query_index,
  output logic [9:0]                    out_match_index,
  output logic [8:0]                    out_distance,
  output logic                          out_mutual,
  output logic                          out_overflow,
  output logic                          out_run_last
);
  import bdmm_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MRD   = 4'd1;
  localparam logic [3:0] ST_MPC   = 4'd2;
  localparam logic [3:0] ST_MSUM  = 4'd3;
  localparam logic [3:0] ST_MUPD  = 4'd4;
  localparam logic [3:0] ST_ORD   = 4'd5;
  localparam logic [3:0] ST_ORB   = 4'd6;
  localparam logic [3:0] ST_OEMIT = 4'd7;
  localparam logic [3:0] ST_EMPTY = 4'd8;

  logic [DESC_W-1:0] qmem  [QUERY_DEPTH];
  logic [DESC_W-1:0] rmem  [REF_DEPTH];
  bdmm_qbest_t       qnmem [QUERY_DEPTH];
  bdmm_rbest_t       rbmem [REF_DEPTH];

  logic [DESC_W-1:0] qrd_r, rrd_r;
  bdmm_qbest_t       qn_rd_r;
  bdmm_rbest_t       rb_rd_r;
  logic [RIDX_W-1:0] rb_addr;

  logic [3:0]        state_r, state_nxt;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              jd_r, jd_nxt;
  logic [QIDX_W-1:0] i_r, i_nxt;
  logic [RIDX_W-1:0] k_r, k_nxt;
  logic [PC_W-1:0]   pc_r [6];
  logic [DIST_W-1:0] d_r;
  bdmm_qbest_t       qb_r, qb_nxt;

  logic              qwe, rwe, qnwe, rbwe;
  logic [QIDX_W-1:0] qwaddr;
  logic [RIDX_W-1:0] rwaddr;
  bdmm_rbest_t       rb_wdata;

  logic              out_valid_r, out_valid_nxt;
  logic              out_free, out_load;
  logic [5:0]        oq_r, oq_nxt;
  logic [9:0]        om_r, om_nxt;
  logic [8:0]        od_r, od_nxt;
  logic              omu_r, omu_nxt, oov_r, oov_nxt, olast_r, olast_nxt;

  logic              row_end, last_q;
  logic [DESC_W-1:0] x;

  assign out_free = !out_valid_r || !out_stall;
  assign cmd_pop  = cmd_valid && (state_r == ST_IDLE);
  assign row_end  = ({1'b0, k_r} + RCNT_W'(1)) == rcnt_r;
  assign last_q   = ({1'b0, i_r} + QCNT_W'(1)) == qcnt_r;
  assign rb_addr  = (state_r == ST_ORB || state_r == ST_OEMIT) ? qn_rd_r.idx : k_r;
  assign x        = qrd_r ^ rrd_r;

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (qwe) qmem[qwaddr] <= cmd.desc;
    if (rwe) rmem[rwaddr] <= cmd.desc;
    if (qnwe) qnmem[i_r] <= qb_nxt;
    if (rbwe) rbmem[k_r] <= rb_wdata;
    qrd_r   <= qmem[i_r];
    rrd_r   <= rmem[k_r];
    qn_rd_r <= qnmem[i_r];
    rb_rd_r <= rbmem[rb_addr];
  end

  // distance datapath
  always_ff @(posedge clk) begin
    for (int w = 0; w < 5; w++) begin
      pc_r[w] <= PC_W'($countones(x[w*64 +: 64]));
    end
    pc_r[5] <= PC_W'($countones(x[DESC_W-1:320]));
    d_r <= DIST_W'(pc_r[0]) + DIST_W'(pc_r[1]) + DIST_W'(pc_r[2])
         + DIST_W'(pc_r[3]) + DIST_W'(pc_r[4]) + DIST_W'(pc_r[5]);
  end

  always_comb begin
    logic [QCNT_W-1:0] qc;
    logic [RCNT_W-1:0] rc;
    logic              ov;
    qc = qcnt_r;
    rc = rcnt_r;
    ov = ovf_r;
    state_nxt = state_r;
    qcnt_nxt  = qcnt_r;
    rcnt_nxt  = rcnt_r;
    ovf_nxt   = ovf_r;
    jd_nxt    = jd_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    qb_nxt    = qb_r;
    qwe = 1'b0;
    rwe = 1'b0;
    qnwe = 1'b0;
    rbwe = 1'b0;
    qwaddr = qcnt_r[QIDX_W-1:0];
    rwaddr = rcnt_r[RIDX_W-1:0];
    rb_wdata = rb_rd_r;
    out_load = 1'b0;
    oq_nxt = oq_r;
    om_nxt = om_r;
    od_nxt = od_r;
    omu_nxt = omu_r;
    oov_nxt = oov_r;
    olast_nxt = olast_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          if (jd_r) begin
            rc = '0;
            ov = 1'b0;
            jd_nxt = 1'b0;
            if (!cmd.is_ref) qc = '0;
          end
          if (cmd.is_ref) begin
            if (rc < RCNT_W'(REF_DEPTH)) begin
              rwe = 1'b1;
              rwaddr = rc[RIDX_W-1:0];
              rc = rc + RCNT_W'(1);
            end else begin
              ov = 1'b1;
            end
          end else begin
            if (qc < QCNT_W'(QUERY_DEPTH)) begin
              qwe = 1'b1;
              qwaddr = qc[QIDX_W-1:0];
              qc = qc + QCNT_W'(1);
            end else begin
              ov = 1'b1;
            end
          end
          qcnt_nxt = qc;
          rcnt_nxt = rc;
          ovf_nxt  = ov;
          if (cmd.start) begin
            jd_nxt = 1'b1;
            i_nxt = '0;
            k_nxt = '0;
            state_nxt = (qc == '0 || rc == '0) ? ST_EMPTY : ST_MRD;
          end
        end
      end
      ST_MRD:  state_nxt = ST_MPC;
      ST_MPC:  state_nxt = ST_MSUM;
      ST_MSUM: state_nxt = ST_MUPD;
      ST_MUPD: begin
        if (k_r == '0 || d_r < qb_r.hdist) begin
          qb_nxt.idx   = k_r;
          qb_nxt.hdist = d_r;
        end
        if (i_r == '0 || d_r < rb_rd_r.hdist) begin
          rb_wdata.idx   = i_r;
          rb_wdata.hdist = d_r;
          rbwe = 1'b1;
        end
        if (row_end) begin
          qnwe = 1'b1;
          k_nxt = '0;
          if (last_q) begin
            i_nxt = '0;
            state_nxt = ST_ORD;
          end else begin
            i_nxt = i_r + QIDX_W'(1);
            state_nxt = ST_MRD;
          end
        end else begin
          k_nxt = k_r + RIDX_W'(1);
          state_nxt = ST_MRD;
        end
      end
      ST_ORD: state_nxt = ST_ORB;
      ST_ORB: state_nxt = ST_OEMIT;
      ST_OEMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          oq_nxt    = i_r;
          om_nxt    = qn_rd_r.idx;
          od_nxt    = qn_rd_r.hdist;
          omu_nxt   = (rb_rd_r.idx == i_r);
          oov_nxt   = ovf_r;
          olast_nxt = last_q;
          if (last_q) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt = i_r + QIDX_W'(1);
            state_nxt = ST_ORD;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load  = 1'b1;
          oq_nxt    = '0;
          om_nxt    = '0;
          od_nxt    = '0;
          omu_nxt   = 1'b0;
          oov_nxt   = ovf_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    qb_r    <= qb_nxt;
    i_r     <= i_nxt;
    k_r     <= k_nxt;
    oq_r    <= oq_nxt;
    om_r    <= om_nxt;
    od_r    <= od_nxt;
    omu_r   <= omu_nxt;
    oov_r   <= oov_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qcnt_r      <= '0;
      rcnt_r      <= '0;
      ovf_r       <= 1'b0;
      jd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qcnt_r      <= qcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      ovf_r       <= ovf_nxt;
      jd_r        <= jd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_query_index = oq_r;
  assign out_match_index = om_r;
  assign out_distance    = od_r;
  assign out_mutual      = omu_r;
  assign out_overflow    = oov_r;
  assign out_run_last    = olast_r;

`ifndef ASSERT_OFF
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUPD) |-> ({1'b0, k_r} < rcnt_r))
    else $error("reference index past stored count");
  a_i_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OEMIT) |-> ({1'b0, i_r} < qcnt_r))
    else $error("query index past stored count");
  a_qcnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCNT_W'(QUERY_DEPTH))
    else $error("query count over depth");
  a_rcnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= RCNT_W'(REF_DEPTH))
    else $error("reference count over depth");
`endif

endmodule

@@ hw/rtl/binary_descriptor_mutual_match_unit.sv @@
// Binary descriptor mutual matcher: top level.
//
// Input channel (in_valid/in_stall): one 352-bit descriptor a word, query
// (in_kind 0) or reference (in_kind 1). Loading takes one word a cycle while
// in_stall is low; a two-word queue sits between input and matching engine.
// A reference word with in_set_last starts a job. The engine compares every
// query against every reference, each pair through read, per-word popcount,
// sum and compare; each result reads its best match and that match's best
// query, then is emitted. No input word is taken by the engine during a job.
// Output channel (out_valid/out_stall): one word per stored query, in query
// order, run_last on the final one; an empty set gives one non-match word.
// A stalled result holds in the output register and the engine waits.
// A query after a finished job clears both sets; a reference after a finished
// job keeps the query set. Reset clears counts, flags and the output valid;
// the descriptor stores need no clearing.
module binary_descriptor_mutual_match_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_desc_w0,
  input  logic [63:0] in_desc_w1,
  input  logic [63:0] in_desc_w2,
  input  logic [63:0] in_desc_w3,
  input  logic [63:0] in_desc_w4,
  input  logic [31:0] in_desc_w5,
  input  logic        in_set_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_query_index,
  output logic [9:0]  out_match_index,
  output logic [8:0]  out_distance,
  output logic        out_mutual,
  output logic        out_overflow,
  output logic        out_run_last
);
  import bdmm_pkg::*;

  logic      cmd_valid;
  logic      cmd_pop;
  bdmm_cmd_t cmd;

  bdmm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_desc_w0  (in_desc_w0),
    .in_desc_w1  (in_desc_w1),
    .in_desc_w2  (in_desc_w2),
    .in_desc_w3  (in_desc_w3),
    .in_desc_w4  (in_desc_w4),
    .in_desc_w5  (in_desc_w5),
    .in_set_last (in_set_last),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  bdmm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_query_index (out_query_index),
    .out_match_index (out_match_index),
    .out_distance    (out_distance),
    .out_mutual      (out_mutual),
    .out_overflow    (out_overflow),
    .out_run_last    (out_run_last)
  );

endmodule
